[rtl/core/lfu_pkg.sv]
// Shared constants for the LFU cache table.
// No dependencies.
package lfu_pkg;
    localparam int ENTRIES_DEF = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 31;
    localparam int CNT_W       = 16;
    localparam int CAP_W       = 5;
    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [1:0] REG_CAPACITY = 2'd0;
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;
endpackage

[rtl/core/lfu_cache_table.sv]
// LFU cache table top level: APB config, stream channels, scan sequencer.
// Uses lfu_pkg. Key, value, count and rank sit in one synchronous memory.
//
// Usage: s_axis carries one operation per item: tdata = {value, key, cmd}.
// m_axis returns one result per item: tdata = {evicted_key, evicted,
// read_value, found}. Every item starts with a scan pass that reads each
// slot of the entry memory (one read a cycle), then a decide step. A get
// that misses then posts its result. Any other item runs a second pass
// that rewrites the recency ranks, then writes the touched or inserted
// entry and posts the result. Results sit in an output register; the
// next item is accepted while a result waits, and the sequencer holds
// its write of a new result until the old one is taken.
// Reset (synchronous, active low) clears valid bits, occupancy and the
// capacity register (to 16); no clearing pass is needed.
// Capacity is at byte address 0 of the APB port; pready is always high.
module lfu_cache_table #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // cmd[0], key[32:1], value[63:33]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // found[0], read_value[31:1],
                                        // evicted[32], evicted_key[64:33]
);
    import lfu_pkg::*;
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] data;
        logic [CNT_W-1:0] cnt;
        logic [IW-1:0]    rank;
    } t_entry;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DEC, S_FIX, S_WR, S_OUT} t_state;

    t_entry          mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [OW-1:0]   r_occ;
    logic [CAP_W-1:0] r_cap;
    t_state          r_state;
    logic [OW-1:0]   r_idx;
    logic [IW-1:0]   r_rdaddr;
    t_entry          r_rd;
    logic            r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic            r_hit;
    logic [IW-1:0]   r_hslot;
    t_entry          r_hent;
    logic            r_vfound;
    logic [IW-1:0]   r_vslot;
    t_entry          r_vent;
    logic            r_ffound;
    logic [IW-1:0]   r_fslot;
    logic            r_ev;
    logic [IW-1:0]   r_rmrank;    // rank removed from the order
    logic            r_dorm;      // a rank shift is needed
    logic            r_ovalid;
    logic [71:0]     r_odata;
    logic            r_wen;
    logic [IW-1:0]   r_waddr;
    t_entry          r_wdata;

    logic [OW-1:0] eff_cap;
    always_comb begin
        eff_cap = (r_cap == '0) ? OW'(1) :
                  ({27'd0, r_cap} > ENTRIES) ? OW'(ENTRIES) : OW'(r_cap);
    end

    logic          do_ev;
    logic [IW-1:0] ins_slot;
    logic [CNT_W-1:0] hit_cnt;
    assign do_ev    = !r_hit && r_cmd == CMD_PUT && r_occ >= eff_cap && r_vfound;
    assign ins_slot = (r_ffound && (!r_ev || r_fslot < r_vslot)) ? r_fslot : r_vslot;
    assign hit_cnt  = (r_hent.cnt == COUNT_MAX) ? COUNT_MAX : r_hent.cnt + CNT_W'(1);

    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == REG_CAPACITY[0:0]) ? {27'd0, r_cap} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cap <= CAP_RESET;
        else if (psel && penable && pwrite && paddr[2:2] == REG_CAPACITY[0:0])
            r_cap <= pwdata[CAP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_wen) mem[r_waddr] <= r_wdata;
        r_rd <= mem[r_rdaddr];
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_valid <= '0; r_occ <= '0;
            r_ovalid <= 1'b0; r_wen <= 1'b0;
            r_rdaddr <= '0; r_idx <= '0;
        end else begin
            r_wen <= 1'b0;
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_cmd <= s_axis_tdata[0];
                    r_key <= s_axis_tdata[32:1];
                    r_val <= s_axis_tdata[63:33];
                    r_hit <= 1'b0; r_vfound <= 1'b0; r_ffound <= 1'b0;
                    r_rdaddr <= (ENTRIES == 1) ? '0 : IW'(1);
                    r_idx <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // r_rd is slot r_idx
                    if (r_valid[r_idx[IW-1:0]]) begin
                        if (r_rd.key == r_key && !r_hit) begin
                            r_hit <= 1'b1; r_hslot <= r_idx[IW-1:0]; r_hent <= r_rd;
                        end
                        if (!r_vfound || r_rd.cnt < r_vent.cnt ||
                            (r_rd.cnt == r_vent.cnt && r_rd.rank < r_vent.rank)) begin
                            r_vfound <= 1'b1; r_vslot <= r_idx[IW-1:0]; r_vent <= r_rd;
                        end
                    end else if (!r_ffound) begin
                        r_ffound <= 1'b1; r_fslot <= r_idx[IW-1:0];
                    end
                    if (r_idx == OW'(ENTRIES-1)) begin
                        r_rdaddr <= '0;
                        r_state <= S_DEC;
                    end else begin
                        r_rdaddr <= (r_rdaddr == IW'(ENTRIES-1)) ? '0 : r_rdaddr + IW'(1);
                        r_idx <= r_idx + OW'(1);
                    end
                end
                S_DEC: begin
                    r_idx <= '0; r_rdaddr <= (ENTRIES == 1) ? '0 : IW'(1);
                    r_ev <= do_ev;
                    r_dorm <= r_hit || do_ev;
                    r_rmrank <= r_hit ? r_hent.rank : r_vent.rank;
                    if (do_ev) begin
                        r_valid[r_vslot] <= 1'b0; r_occ <= r_occ - OW'(1);
                    end
                    r_state <= (r_hit || r_cmd == CMD_PUT) ? S_FIX : S_OUT;
                end
                S_FIX: begin
                    // shift ranks above the removed one
                    if (r_dorm && r_valid[r_idx[IW-1:0]] &&
                        !(r_hit && r_idx[IW-1:0] == r_hslot) && r_rd.rank > r_rmrank) begin
                        r_wen <= 1'b1; r_waddr <= r_idx[IW-1:0];
                        r_wdata <= '{key: r_rd.key, data: r_rd.data, cnt: r_rd.cnt,
                                     rank: r_rd.rank - IW'(1)};
                    end
                    r_rdaddr <= (r_rdaddr == IW'(ENTRIES-1)) ? '0 : r_rdaddr + IW'(1);
                    if (r_idx == OW'(ENTRIES-1)) r_state <= S_WR;
                    else r_idx <= r_idx + OW'(1);
                end
                S_WR: begin
                    // write the touched or inserted entry
                    r_state <= S_OUT;
                    if (r_hit) begin
                        r_wen <= 1'b1; r_waddr <= r_hslot;
                        r_wdata <= '{key: r_hent.key,
                                     data: (r_cmd == CMD_PUT) ? r_val : r_hent.data,
                                     cnt: hit_cnt, rank: IW'(r_occ - OW'(1))};
                    end else if (r_ev || r_ffound) begin
                        r_wen <= 1'b1;
                        r_waddr <= ins_slot;
                        r_valid[ins_slot] <= 1'b1;
                        r_wdata <= '{key: r_key, data: r_val, cnt: CNT_W'(1),
                                     rank: IW'(r_occ)};
                        r_occ <= r_occ + OW'(1);
                    end
                end
                S_OUT: if (!r_ovalid || m_axis_tready) begin
                    r_ovalid <= 1'b1;
                    r_odata <= {7'd0, (r_ev ? r_vent.key : 32'd0), r_ev,
                                ((r_hit && r_cmd == CMD_GET) ? r_hent.data : 31'd0), r_hit};
                    r_rdaddr <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(ENTRIES)) else $error("occupancy overflow");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ) || r_state == S_FIX)
        else $error("valid count mismatch");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=> r_ovalid) else $error("result lost");
endmodule

[tb/sv/tb_lfu_cache_table.sv]
// Self-checking testbench for lfu_cache_table: directed table, then random ops.
// Holds its own LFU/LRU table model for expected results. Uses lfu_pkg.
module tb_lfu_cache_table;
    timeunit 1ns;
    timeprecision 1ps;
    import lfu_pkg::*;

    localparam int N         = ENTRIES_DEF;
    localparam int DRAIN     = 2 * N + 8;
    localparam int WD_LIMIT  = 5000;
    localparam int POOL_SIZE = 24;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } t_lfu_result;

    typedef enum logic {ROW_OP, ROW_CAP} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic             cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             typed;
        t_lfu_result      want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // cmd[0], key[32:1], value[63:33]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;        // found[0], read_value[31:1],
                                      // evicted[32], evicted_key[64:33]

    lfu_cache_table dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // table model
    logic [CAP_W-1:0] cap_reg = CAP_RESET;
    logic             tbl_valid [N];
    logic [KEY_W-1:0] tbl_key   [N];
    logic [VAL_W-1:0] tbl_data  [N];
    logic [CNT_W-1:0] tbl_count [N];
    int unsigned      tbl_rank  [N];
    int unsigned      occupancy = 0;

    t_lfu_result pending_results[$];
    int          fail_count = 0;
    int          tx_idle = 0, rx_idle = 0;
    int          stall_cycles = 0;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    function automatic void drop_rank(int s);
        for (int i = 0; i < N; i++)
            if (tbl_valid[i] && i != s && tbl_rank[i] > tbl_rank[s])
                tbl_rank[i]--;
    endfunction

    function automatic t_lfu_result lfu_predict(logic cmd, logic [KEY_W-1:0] key,
                                                logic [VAL_W-1:0] value);
        t_lfu_result r;
        int hit, victim, slot, eff_cap;
        r = '0;
        hit = -1;
        victim = -1;
        slot = -1;
        eff_cap = (cap_reg < 1) ? 1 : (cap_reg > N) ? N : int'(cap_reg);
        for (int i = 0; i < N; i++)
            if (hit < 0 && tbl_valid[i] && tbl_key[i] == key) hit = i;
        if (hit >= 0) begin
            r.found = 1'b1;
            if (cmd == CMD_GET) r.read_value = tbl_data[hit];
            else tbl_data[hit] = value;
            drop_rank(hit);
            tbl_rank[hit] = occupancy - 1;
            if (tbl_count[hit] != COUNT_MAX) tbl_count[hit]++;
        end else if (cmd == CMD_PUT) begin
            if (occupancy >= eff_cap) begin
                for (int i = 0; i < N; i++)
                    if (tbl_valid[i] && (victim < 0 || tbl_count[i] < tbl_count[victim] ||
                        (tbl_count[i] == tbl_count[victim] &&
                         tbl_rank[i] < tbl_rank[victim])))
                        victim = i;
                if (victim >= 0) begin
                    r.evicted = 1'b1;
                    r.evicted_key = tbl_key[victim];
                    drop_rank(victim);
                    tbl_valid[victim] = 1'b0;
                    occupancy--;
                end
            end
            for (int i = 0; i < N; i++)
                if (slot < 0 && !tbl_valid[i]) slot = i;
            if (slot >= 0) begin
                tbl_valid[slot] = 1'b1;
                tbl_key[slot] = key;
                tbl_data[slot] = value;
                tbl_count[slot] = CNT_W'(1);
                tbl_rank[slot] = occupancy;
                occupancy++;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp, $realtime);
        fail_count++;
    endtask

    // result checker, output stall and watchdog
    always @(posedge i_clk) begin
        t_lfu_result got, exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[0], m_axis_tdata[31:1], m_axis_tdata[32],
                   m_axis_tdata[64:33]};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", 64'(got.evicted_key), 64'h0);
            end else begin
                exp = pending_results.pop_front();
                if (got.found != exp.found)
                    report_mismatch("found", 64'(got.found), 64'(exp.found));
                if (got.read_value != exp.read_value)
                    report_mismatch("read_value", 64'(got.read_value), 64'(exp.read_value));
                if (got.evicted != exp.evicted)
                    report_mismatch("evicted", 64'(got.evicted), 64'(exp.evicted));
                if (got.evicted_key != exp.evicted_key)
                    report_mismatch("evicted_key", 64'(got.evicted_key),
                                    64'(exp.evicted_key));
                if (m_axis_tdata[71:65] != '0)
                    report_mismatch("pad bits", 64'(m_axis_tdata[71:65]), 64'h0);
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WD_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", WD_LIMIT);
            $display("Verification failed");
            $finish;
        end
        m_axis_tready <= (int'($urandom_range(99)) >= rx_idle);
    end

    task automatic send_op(logic cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value,
                           logic typed, t_lfu_result want);
        t_lfu_result r;
        if (int'($urandom_range(99)) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while (int'($urandom_range(99)) < tx_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, key, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        r = lfu_predict(cmd, key, value);
        pending_results.push_back(typed ? want : r);
    endtask

    task automatic write_capacity(logic [31:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 3'(REG_CAPACITY) << 2; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        cap_reg = v[CAP_W-1:0];
    endtask

    task automatic random_op();
        logic cmd;
        logic [KEY_W-1:0] key;
        cmd = 1'($urandom_range(1));
        key = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(POOL_SIZE-1)];
        send_op(cmd, key, VAL_W'($urandom()), 1'b0, '0);
    endtask

    t_dir_row dir_rows[$];

    function automatic t_dir_row op_row(logic cmd, logic [KEY_W-1:0] key,
                                        logic [VAL_W-1:0] value, logic typed,
                                        t_lfu_result want);
        t_dir_row d;
        d.kind = ROW_OP; d.cmd = cmd; d.key = key; d.value = value;
        d.typed = typed; d.want = want;
        return d;
    endfunction

    function automatic t_dir_row cap_row(logic [KEY_W-1:0] v);
        t_dir_row d;
        d = op_row(CMD_GET, v, '0, 1'b0, '0);
        d.kind = ROW_CAP;
        return d;
    endfunction

    initial begin
        int caps[$];
        for (int i = 0; i < N; i++) begin
            tbl_valid[i] = 1'b0; tbl_key[i] = '0; tbl_data[i] = '0;
            tbl_count[i] = '0; tbl_rank[i] = 0;
        end
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();

        dir_rows.push_back(op_row(CMD_GET, 32'h0, 31'h0, 1'b1, '0));
        dir_rows.push_back(op_row(CMD_PUT, 32'h0, 31'h0, 1'b1, '0));
        dir_rows.push_back(op_row(CMD_PUT, 32'hFFFFFFFF, 31'h7FFFFFFF, 1'b1, '0));
        dir_rows.push_back(op_row(CMD_GET, 32'hFFFFFFFF, 31'h0, 1'b1,
                                  {1'b1, 31'h7FFFFFFF, 1'b0, 32'h0}));
        dir_rows.push_back(op_row(CMD_GET, 32'h0, 31'h7FFFFFFF, 1'b1,
                                  {1'b1, 31'h0, 1'b0, 32'h0}));
        dir_rows.push_back(op_row(CMD_PUT, 32'h0, 31'h2AAAAAAA, 1'b1,
                                  {1'b1, 31'h0, 1'b0, 32'h0}));
        dir_rows.push_back(op_row(CMD_GET, 32'h0, 31'h0, 1'b1,
                                  {1'b1, 31'h2AAAAAAA, 1'b0, 32'h0}));
        dir_rows.push_back(op_row(CMD_PUT, 32'h12345678, 31'h55555555, 1'b1, '0));
        // capacity lowered below occupancy: each insert evicts one
        dir_rows.push_back(cap_row(1));
        dir_rows.push_back(op_row(CMD_PUT, 32'hA5A5A5A5, 31'h1, 1'b1,
                                  {1'b0, 31'h0, 1'b1, 32'h12345678}));
        dir_rows.push_back(op_row(CMD_PUT, 32'h5A5A5A5A, 31'h2, 1'b0, '0));
        dir_rows.push_back(op_row(CMD_GET, 32'hA5A5A5A5, 31'h0, 1'b0, '0));
        dir_rows.push_back(cap_row(0));   // clamps to one
        dir_rows.push_back(op_row(CMD_PUT, 32'h00000001, 31'h3, 1'b0, '0));
        dir_rows.push_back(op_row(CMD_PUT, 32'h80000000, 31'h4, 1'b0, '0));
        dir_rows.push_back(op_row(CMD_GET, 32'h00000001, 31'h0, 1'b0, '0));
        dir_rows.push_back(cap_row(31));  // clamps to table size
        for (int i = 0; i < 6; i++)
            dir_rows.push_back(op_row(CMD_PUT, 32'h100 + i, 31'(i), 1'b0, '0));
        dir_rows.push_back(op_row(CMD_GET, 32'h101, 31'h0, 1'b0, '0));
        dir_rows.push_back(cap_row(16));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CAP) write_capacity(dir_rows[i].key);
            else send_op(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].value,
                         dir_rows[i].typed, dir_rows[i].want);
        end

        caps = '{2, 16, 5, 1, 12, 31, 3, 8, 0};
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle = (ph == 0) ? 24 : (ph == 1) ? 85 : 0;
            rx_idle = (ph == 0) ? 85 : (ph == 1) ? 24 : 0;
            for (int c = 0; c < 3; c++) begin
                write_capacity(caps[ph * 3 + c]);
                repeat (45) random_op();
            end
        end
        write_capacity($urandom_range(31));
        repeat (30) random_op();

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
